### sv/prrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// Types, constants and helpers shared by the read request splitter.
// ----------------------------------------------------------------------------
package prrs_pkg;

  // Largest read request in dwords
  localparam int MAX_READ_DW    = 16;
  // Page size in bytes (power of two); requests never cross a page
  localparam int PAGE_BYTES     = 4096;
  // Larger read commands are clamped to this
  localparam int MAX_SIZE_BYTES = 65536;
  localparam int PAGE_BITS      = $clog2(PAGE_BYTES);

  // Output queue depth; must hold at least two results
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  localparam logic [7:0] TYPE_MRD64 = 8'h20;
  localparam logic [7:0] TYPE_CPLD  = 8'h4a;
  localparam logic [7:0] BYTE_EN    = 8'hff;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_CPL_HDR = 2'd1,
    REQ_CPL_DW  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_ADDR_ALIGN = 3'd0,
    ERR_SIZE_ALIGN = 3'd1,
    ERR_NO_REQ_ID  = 3'd2,
    ERR_CPL_TYPE   = 3'd3,
    ERR_TAG        = 3'd4
  } error_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] byte_addr;
    logic [16:0] size_bytes;
    logic [31:0] word;
    logic [31:0] cpl_dw2;
    logic [8:0]  cpl_total_dw;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] hdr_dw0;
    logic [31:0] hdr_dw1;
    logic [31:0] addr_hi;
    logic [31:0] addr_lo;
    logic [31:0] data_word;
    logic [2:0]  error_code;
    logic        last;
  } rsp_t;

  // Queue push request: up to two results per beat
  typedef struct packed {
    logic push0;
    logic push1;
    rsp_t rsp0;
    rsp_t rsp1;
  } oq_push_t;

endpackage

### sv/prrs_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_out_queue
// Small result queue: takes up to two results per cycle, hands out one when not stalled.
// ----------------------------------------------------------------------------
module prrs_out_queue
  import prrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  oq_push_t push,
  output logic     room2,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp
);

  rsp_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_PTR_W:0]   count;
  logic [OQ_PTR_W-1:0] wr_ptr1;
  logic                pop;
  logic [OQ_PTR_W:0]   n_push;

  assign wr_ptr1   = wr_ptr + OQ_PTR_W'(1);
  assign rsp_valid = (count != '0);
  assign rsp       = mem[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;
  // push1 only comes with push0
  assign n_push    = (OQ_PTR_W+1)'(push.push0) + (OQ_PTR_W+1)'(push.push1);
  // conservative: ignores a pop in the same cycle
  assign room2     = (count <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.rsp0;
    end
    if (push.push1) begin
      mem[wr_ptr1] <= push.rsp1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + n_push - (OQ_PTR_W+1)'(pop);
    end
  end

endmodule

### sv/pcie_read_request_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcie_read_request_splitter
// Splits a read command into MRd64 request headers, checks completion
// headers and passes payload dwords out byte-swapped.
// ----------------------------------------------------------------------------
// One command beat is taken per cycle. Each beat is held in an input register
// while the control logic works it out, and its results (none, one or two) go
// into a four-entry output queue. A beat that yields two results (last payload
// dword of a chunk, followed by the next header or read done) needs two output
// beats, so over a long run the output port, one result per cycle while the
// output is not stalled, sets the rate. The input stalls while a beat is staged
// and the queue cannot take two more results. Write requester_id through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module pcie_read_request_splitter
  import prrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Chunk length: capped by max read size, room left in the page, and
  // dwords still to read.
  function automatic logic [8:0] chunk_dw(input logic [PAGE_BITS-1:0] off,
                                          input logic [14:0] rem);
    logic [15:0] lim;
    logic [15:0] room;
    lim  = 16'(MAX_READ_DW);
    room = (16'(PAGE_BYTES) - 16'(off)) >> 2;
    if (off != '0 && room < lim) begin
      lim = room;
    end
    if (16'(rem) < lim) begin
      lim = 16'(rem);
    end
    return 9'(lim);
  endfunction

  logic [15:0] requester_id;
  logic [63:0] cur_address,    cur_address_next;
  logic [14:0] remaining_dw,   remaining_dw_next;
  logic [7:0]  tag_counter,    tag_counter_next;
  logic [8:0]  chunk_len,      chunk_len_next;
  logic [8:0]  chunk_received, chunk_received_next;
  logic [8:0]  cpl_words_left, cpl_words_left_next;
  logic        busy,           busy_next;

  logic        stage_valid;
  cmd_t        stage;
  logic        room2;
  logic        advance;
  oq_push_t    push;

  assign advance   = stage_valid && room2;
  assign cmd_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      stage <= cmd;
    end
  end

  // Work for the staged beat
  always_comb begin
    logic [31:0] size_c;
    logic [8:0]  len;
    logic [8:0]  need;
    rsp_t        hdr;

    cur_address_next    = cur_address;
    remaining_dw_next   = remaining_dw;
    tag_counter_next    = tag_counter;
    chunk_len_next      = chunk_len;
    chunk_received_next = chunk_received;
    cpl_words_left_next = cpl_words_left;
    busy_next           = busy;
    push                = '0;
    size_c              = '0;
    len                 = '0;
    need                = '0;
    hdr                 = '0;

    if (advance) begin
      case (stage.req_type)
        REQ_START: begin
          busy_next           = 1'b0;
          cpl_words_left_next = '0;
          push.push0          = 1'b1;
          push.rsp0.last      = 1'b1;
          size_c              = 32'(stage.size_bytes);
          if (size_c > 32'(MAX_SIZE_BYTES)) begin
            size_c = 32'(MAX_SIZE_BYTES) & ~32'd3;
          end
          if (stage.byte_addr[1:0] != 2'b00) begin
            push.rsp0.result_kind = KIND_ERR;
            push.rsp0.error_code  = ERR_ADDR_ALIGN;
          end else if (stage.size_bytes[1:0] != 2'b00) begin
            push.rsp0.result_kind = KIND_ERR;
            push.rsp0.error_code  = ERR_SIZE_ALIGN;
          end else if (requester_id == '0) begin
            push.rsp0.result_kind = KIND_ERR;
            push.rsp0.error_code  = ERR_NO_REQ_ID;
          end else if (size_c == '0) begin
            push.rsp0.result_kind = KIND_DONE;
          end else begin
            cur_address_next    = stage.byte_addr;
            remaining_dw_next   = 15'(size_c >> 2);
            busy_next           = 1'b1;
            chunk_received_next = '0;
            chunk_len_next      = chunk_dw(stage.byte_addr[PAGE_BITS-1:0],
                                           15'(size_c >> 2));
          end
        end
        REQ_CPL_HDR: begin
          if (busy) begin
            cpl_words_left_next = '0;
            if (stage.word[31:24] != TYPE_CPLD) begin
              busy_next             = 1'b0;
              push.push0            = 1'b1;
              push.rsp0.result_kind = KIND_ERR;
              push.rsp0.error_code  = ERR_CPL_TYPE;
              push.rsp0.last        = 1'b1;
            end else if (stage.cpl_dw2[15:8] != tag_counter) begin
              busy_next             = 1'b0;
              push.push0            = 1'b1;
              push.rsp0.result_kind = KIND_ERR;
              push.rsp0.error_code  = ERR_TAG;
              push.rsp0.last        = 1'b1;
            end else begin
              len  = (stage.cpl_total_dw >= 9'd3) ? stage.cpl_total_dw - 9'd3 : '0;
              need = chunk_len - chunk_received;
              cpl_words_left_next = (len < need) ? len : need;
            end
          end
        end
        REQ_CPL_DW: begin
          if (busy && cpl_words_left != '0) begin
            cpl_words_left_next   = cpl_words_left - 9'd1;
            chunk_received_next   = chunk_received + 9'd1;
            remaining_dw_next     = remaining_dw - 15'd1;
            cur_address_next      = cur_address + 64'd4;
            push.push0            = 1'b1;
            push.rsp0.result_kind = KIND_DATA;
            push.rsp0.data_word   = byte_swap(stage.word);
            if (chunk_received_next < chunk_len) begin
              push.rsp0.last = 1'b1;
            end else begin
              // chunk complete: next header or read done follows
              tag_counter_next    = tag_counter + 8'd1;
              cpl_words_left_next = '0;
              push.push1          = 1'b1;
              push.rsp1.last      = 1'b1;
              if (remaining_dw_next == '0) begin
                busy_next             = 1'b0;
                push.rsp1.result_kind = KIND_DONE;
              end else begin
                chunk_received_next = '0;
                chunk_len_next      = chunk_dw(cur_address_next[PAGE_BITS-1:0],
                                               remaining_dw_next);
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Request header for a newly issued chunk
      hdr.result_kind = KIND_HDR;
      hdr.hdr_dw0     = {TYPE_MRD64, 15'd0, chunk_len_next};
      hdr.hdr_dw1     = {requester_id, tag_counter_next, BYTE_EN};
      hdr.addr_hi     = cur_address_next[63:32];
      hdr.addr_lo     = cur_address_next[31:0];
      hdr.last        = 1'b1;
      if (stage.req_type == REQ_START && busy_next) begin
        push.rsp0 = hdr;
      end
      if (push.push1 && busy_next) begin
        push.rsp1 = hdr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      requester_id   <= '0;
      cur_address    <= '0;
      remaining_dw   <= '0;
      tag_counter    <= '0;
      chunk_len      <= '0;
      chunk_received <= '0;
      cpl_words_left <= '0;
      busy           <= 1'b0;
      stage_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        requester_id <= cfg_wr_data;
      end
      cur_address    <= cur_address_next;
      remaining_dw   <= remaining_dw_next;
      tag_counter    <= tag_counter_next;
      chunk_len      <= chunk_len_next;
      chunk_received <= chunk_received_next;
      cpl_words_left <= cpl_words_left_next;
      busy           <= busy_next;
      if (cmd_valid && !cmd_stall) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  prrs_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
